/* hw/rtl/rid_pkg.sv */
// rid_pkg: decode codes, lookup tables and result type for the instruction decoder
package rid_pkg;

  // mnemonic codes; the primary opcode mnemonics come first, in the order of the primary table
  typedef enum logic [7:0] {
    MN_J, MN_JAL, MN_BEQ, MN_BNE, MN_ADDIU, MN_SLTI, MN_SLTIU, MN_ANDI,
    MN_ORI, MN_XORI, MN_AUI, MN_COP0, MN_COP1, MN_COP2, MN_LB, MN_LH,
    MN_LW, MN_LBU, MN_LHU, MN_SB, MN_SH, MN_SW, MN_BC, MN_BALC,
    MN_SLL, MN_CLZ, MN_ADD, MN_TGE, MN_JALR, MN_CLO, MN_ADDU, MN_TGEU,
    MN_SUB, MN_SLT, MN_TLT, MN_SRA, MN_SUBU, MN_SLTU, MN_TLTU, MN_SLLV,
    MN_SYSCALL, MN_AND, MN_TEQ, MN_LSA, MN_BREAK, MN_OR, MN_SELEQZ, MN_SDBBP,
    MN_XOR, MN_TNE, MN_SRAV, MN_SYNC, MN_NOR, MN_SELNEZ,
    MN_BLTZ, MN_BGEZ, MN_SIGRIE, MN_SYNCI,
    MN_EXT, MN_INS, MN_PREF, MN_LL,
    MN_ADDIUPC, MN_LWPC, MN_AUIPC, MN_ALUIPC,
    MN_BITSWAP, MN_WSBH, MN_ALIGN, MN_SEB, MN_SEH,
    MN_BEQC, MN_BOVC, MN_BNEC, MN_BNVC, MN_JIC, MN_JIALC,
    MN_MUL, MN_MUH, MN_MULU, MN_MUHU, MN_DIV, MN_MOD, MN_DIVU, MN_MODU,
    MN_SRL, MN_ROTR, MN_SRLV, MN_ROTRV
  } mnem_t;

  // non-valid classes; the low three bits are the class number
  typedef enum logic [7:0] {
    CL_REMOVED = 8'hF1,
    CL_RESB    = 8'hF2,
    CL_RSTAR   = 8'hF3,
    CL_NOMOD   = 8'hF4,
    CL_DEPR    = 8'hF5,
    CL_BAD     = 8'hF6
  } cls_code_t;

  // table entries that need a second level of decode
  typedef enum logic [7:0] {
    GR_SPECIAL  = 8'hE0,
    GR_REGIMM   = 8'hE1,
    GR_POP10    = 8'hE2,
    GR_POP30    = 8'hE3,
    GR_SPECIAL3 = 8'hE4,
    GR_POP66    = 8'hE5,
    GR_POP76    = 8'hE6,
    GR_PCREL    = 8'hE7,
    GR_SRL      = 8'hE8,
    GR_SRLV     = 8'hE9,
    GR_SOP      = 8'hEA,
    GR_BSHFL    = 8'hEB
  } group_t;

  localparam logic [2:0] CLASS_VALID = 3'd0;
  localparam logic [3:0] CLASS_NIBBLE = 4'hF;

  typedef struct packed {
    logic [2:0] decode_class;
    logic [6:0] mnemonic_index;
    logic       control_transfer;
  } result_t;

  // primary opcode table
  localparam logic [7:0] TOP_TAB [0:63] = '{
    GR_SPECIAL, GR_REGIMM, MN_J, MN_JAL, MN_BEQ, MN_BNE, CL_NOMOD, CL_NOMOD,
    GR_POP10, MN_ADDIU, MN_SLTI, MN_SLTIU, MN_ANDI, MN_ORI, MN_XORI, MN_AUI,
    MN_COP0, MN_COP1, MN_COP2, CL_REMOVED, CL_REMOVED, CL_REMOVED, CL_NOMOD, CL_NOMOD,
    GR_POP30, CL_RESB, CL_RESB, CL_RESB, CL_RSTAR, CL_NOMOD, CL_NOMOD, GR_SPECIAL3,
    MN_LB, MN_LH, CL_REMOVED, MN_LW, MN_LBU, MN_LHU, CL_REMOVED, CL_RESB,
    MN_SB, MN_SH, CL_REMOVED, MN_SW, CL_RESB, CL_RESB, CL_REMOVED, CL_REMOVED,
    CL_REMOVED, CL_NOMOD, MN_BC, CL_REMOVED, CL_RESB, CL_NOMOD, GR_POP66, CL_RESB,
    CL_REMOVED, CL_NOMOD, MN_BALC, GR_PCREL, CL_RESB, CL_NOMOD, GR_POP76, CL_RESB
  };

  // special group, selected by funct
  localparam logic [7:0] SPECIAL_TAB [0:63] = '{
    MN_SLL, CL_REMOVED, GR_SRL, MN_SRA, MN_SLLV, MN_LSA, GR_SRLV, MN_SRAV,
    CL_REMOVED, MN_JALR, CL_REMOVED, CL_REMOVED, MN_SYSCALL, MN_BREAK, MN_SDBBP, MN_SYNC,
    MN_CLZ, MN_CLO, CL_REMOVED, CL_REMOVED, CL_RESB, CL_RESB, CL_RESB, CL_RESB,
    GR_SOP, GR_SOP, GR_SOP, GR_SOP, CL_RESB, CL_RESB, CL_RESB, CL_RESB,
    MN_ADD, MN_ADDU, MN_SUB, MN_SUBU, MN_AND, MN_OR, MN_XOR, MN_NOR,
    CL_RSTAR, CL_RSTAR, MN_SLT, MN_SLTU, CL_RESB, CL_RESB, CL_RESB, CL_RESB,
    MN_TGE, MN_TGEU, MN_TLT, MN_TLTU, MN_TEQ, MN_SELEQZ, MN_TNE, MN_SELNEZ,
    CL_RESB, CL_RSTAR, CL_RESB, CL_RESB, CL_RESB, CL_RSTAR, CL_RESB, CL_RESB
  };

  // regimm group, selected by rt
  localparam logic [7:0] REGIMM_TAB [0:31] = '{
    MN_BLTZ, MN_BGEZ, CL_REMOVED, CL_REMOVED, CL_RSTAR, CL_RSTAR, CL_NOMOD, CL_NOMOD,
    CL_REMOVED, CL_REMOVED, CL_REMOVED, CL_REMOVED, CL_REMOVED, CL_RSTAR, CL_REMOVED,
    CL_RSTAR,
    CL_DEPR, CL_DEPR, CL_REMOVED, CL_REMOVED, CL_RSTAR, CL_RSTAR, CL_RSTAR, MN_SIGRIE,
    CL_RSTAR, CL_RSTAR, CL_RSTAR, CL_RSTAR, CL_NOMOD, CL_NOMOD, CL_NOMOD, MN_SYNCI
  };

  // special3 group, selected by funct
  localparam logic [7:0] SPECIAL3_TAB [0:63] = '{
    MN_EXT, CL_RESB, CL_RESB, CL_RESB, MN_INS, CL_RESB, CL_RESB, CL_RESB,
    CL_NOMOD, CL_NOMOD, CL_NOMOD, CL_RSTAR, CL_NOMOD, CL_NOMOD, CL_RSTAR, CL_RSTAR,
    CL_NOMOD, CL_NOMOD, CL_NOMOD, CL_NOMOD, CL_NOMOD, CL_NOMOD, CL_NOMOD, CL_NOMOD,
    CL_NOMOD, CL_REMOVED, CL_REMOVED, CL_NOMOD, CL_NOMOD, CL_NOMOD, CL_NOMOD, CL_NOMOD,
    GR_BSHFL, CL_REMOVED, CL_REMOVED, CL_NOMOD, CL_RESB, CL_NOMOD, CL_NOMOD, CL_RESB,
    CL_NOMOD, CL_NOMOD, CL_RSTAR, CL_RSTAR, CL_NOMOD, CL_NOMOD, CL_NOMOD, CL_NOMOD,
    CL_NOMOD, CL_NOMOD, CL_RSTAR, CL_RSTAR, CL_NOMOD, MN_PREF, MN_LL, CL_RESB,
    CL_NOMOD, CL_RSTAR, CL_RSTAR, CL_NOMOD, CL_NOMOD, CL_RSTAR, CL_RSTAR, CL_RSTAR
  };

  // bshfl group, selected by shamt
  function automatic logic [7:0] bshfl_lookup(input logic [4:0] sa);
    logic [7:0] code;
    case (sa)
      5'd0:                     code = MN_BITSWAP;
      5'd2:                     code = MN_WSBH;
      5'd8, 5'd9, 5'd10, 5'd11: code = MN_ALIGN;
      5'd16:                    code = MN_SEB;
      5'd24:                    code = MN_SEH;
      default:                  code = CL_RSTAR;
    endcase
    return code;
  endfunction

  // pc-relative group, selected by rt
  function automatic logic [7:0] pcrel_lookup(input logic [4:0] rt);
    logic [7:0] code;
    if (rt < 5'd8) begin
      code = MN_ADDIUPC;
    end else if (rt < 5'd16) begin
      code = MN_LWPC;
    end else if (rt < 5'd28) begin
      code = CL_NOMOD;
    end else if (rt == 5'd30) begin
      code = MN_AUIPC;
    end else if (rt == 5'd31) begin
      code = MN_ALUIPC;
    end else begin
      code = CL_BAD;
    end
    return code;
  endfunction

  // compact branch pairs: ordered compare of rs and rt
  function automatic logic [7:0] pop_compare(input logic [4:0] rs, input logic [4:0] rt,
                                             input logic [7:0] eq, input logic [7:0] ov);
    logic [7:0] code;
    if (rs < rt && rs != 5'd0) begin
      code = eq;
    end else if (rs >= rt) begin
      code = ov;
    end else begin
      code = CL_NOMOD;
    end
    return code;
  endfunction

  // branch and jump mnemonics
  function automatic logic is_branch(input logic [7:0] code);
    logic hit;
    case (code)
      MN_J, MN_JAL, MN_JALR, MN_JIALC, MN_JIC, MN_BALC, MN_BC, MN_BEQ,
      MN_BEQC, MN_BGEZ, MN_BLTZ, MN_BNE, MN_BNEC, MN_BNVC, MN_BOVC: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

/* hw/rtl/risc_instruction_decoder.sv */
// risc_instruction_decoder: top level of the registered instruction classifier
//
//   channel | signals                                   | beat
//   --------+-------------------------------------------+-----------------------------
//   input   | in_valid, in_ready, instruction_word      | one 32-bit instruction
//   output  | out_valid, out_ready, decode_class,       | class, mnemonic, branch flag
//           | mnemonic_index, control_transfer          |
//
// one beat per cycle sustained while out_ready is high
// a result passes through the input register and then the result register around the table decode
// rst clears both stage valid bits; payload registers are not reset
// with out_ready low the result register holds and one more beat waits in the input register
// in_ready follows out_ready combinationally through both stages
module risc_instruction_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instruction_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  decode_class,
  output logic [6:0]  mnemonic_index,
  output logic        control_transfer
);

  logic             stage_valid;
  logic             stage_ready;
  logic [31:0]      stage_word;
  rid_pkg::result_t stage_result;
  rid_pkg::result_t out_result;

  // input register
  rid_in_reg u_in_reg (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .instruction_word (instruction_word),
    .hold_valid       (stage_valid),
    .down_ready       (stage_ready),
    .word             (stage_word)
  );

  // table decode
  rid_classify u_classify (
    .word   (stage_word),
    .result (stage_result)
  );

  // result register
  rid_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (stage_valid),
    .up_ready   (stage_ready),
    .up_result  (stage_result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign decode_class     = out_result.decode_class;
  assign mnemonic_index   = out_result.mnemonic_index;
  assign control_transfer = out_result.control_transfer;

  // a non-valid class carries no mnemonic and no branch flag
  a_class_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && decode_class != rid_pkg::CLASS_VALID |->
      mnemonic_index == 7'd0 && !control_transfer)
    else $error("non-valid class with mnemonic or branch flag set");

  // codes stay inside their ranges
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> decode_class <= 3'd6 && mnemonic_index <= 7'd88)
    else $error("decode result out of range");

  // a ready sink never stalls the input side
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output ready");

  // an accepted beat moves through both registers to the output when the sink is ready
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted beat did not reach the output");

endmodule

/* hw/rtl/rid_in_reg.sv */
// rid_in_reg: input register holding one instruction word beat
module rid_in_reg (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instruction_word,
  output logic        hold_valid,
  input  logic        down_ready,
  output logic [31:0] word
);

  logic load;
  logic hold_valid_next;

  // free when empty or when the held word moves on this cycle
  assign in_ready = !hold_valid || down_ready;
  assign load     = in_valid && in_ready;
  assign hold_valid_next = load || (hold_valid && !down_ready);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      word <= instruction_word;
    end
  end

endmodule

/* hw/rtl/rid_classify.sv */
// rid_classify: nested table decode of one instruction word into a result
module rid_classify (
  input  logic [31:0]           word,
  output rid_pkg::result_t      result
);

  logic [5:0] op;
  logic [4:0] rs;
  logic [4:0] rt;
  logic [4:0] sa;
  logic [5:0] fn;
  logic [7:0] top_code;
  logic [7:0] sub_code;
  logic [7:0] code;

  assign op = word[31:26];
  assign rs = word[25:21];
  assign rt = word[20:16];
  assign sa = word[10:6];
  assign fn = word[5:0];

  // first and second level lookup
  always_comb begin
    top_code = rid_pkg::TOP_TAB[op];
    sub_code = rid_pkg::SPECIAL_TAB[fn];
    case (top_code)
      rid_pkg::GR_SPECIAL: begin
        case (sub_code)
          rid_pkg::GR_SRL:  code = word[21] ? 8'(rid_pkg::MN_ROTR) : 8'(rid_pkg::MN_SRL);
          rid_pkg::GR_SRLV: code = word[6] ? 8'(rid_pkg::MN_ROTRV) : 8'(rid_pkg::MN_SRLV);
          rid_pkg::GR_SOP: begin
            if (sa == 5'd2 || sa == 5'd3) begin
              code = 8'(rid_pkg::MN_MUL) + {5'd0, fn[1:0], sa[0]};
            end else begin
              code = rid_pkg::CL_NOMOD;
            end
          end
          default: code = sub_code;
        endcase
      end
      rid_pkg::GR_REGIMM: code = rid_pkg::REGIMM_TAB[rt];
      rid_pkg::GR_POP10:
        code = rid_pkg::pop_compare(rs, rt, rid_pkg::MN_BEQC, rid_pkg::MN_BOVC);
      rid_pkg::GR_POP30:
        code = rid_pkg::pop_compare(rs, rt, rid_pkg::MN_BNEC, rid_pkg::MN_BNVC);
      rid_pkg::GR_SPECIAL3: begin
        if (rid_pkg::SPECIAL3_TAB[fn] == 8'(rid_pkg::GR_BSHFL)) begin
          code = rid_pkg::bshfl_lookup(sa);
        end else begin
          code = rid_pkg::SPECIAL3_TAB[fn];
        end
      end
      rid_pkg::GR_POP66: code = (rs == 5'd0) ? 8'(rid_pkg::MN_JIC) : 8'(rid_pkg::CL_NOMOD);
      rid_pkg::GR_POP76: code = (rs == 5'd0) ? 8'(rid_pkg::MN_JIALC) : 8'(rid_pkg::CL_NOMOD);
      rid_pkg::GR_PCREL: code = rid_pkg::pcrel_lookup(rt);
      default:           code = top_code;
    endcase
  end

  // split the code into class, mnemonic and branch flag
  always_comb begin
    if (code[7:4] == rid_pkg::CLASS_NIBBLE) begin
      result.decode_class     = code[2:0];
      result.mnemonic_index   = 7'd0;
      result.control_transfer = 1'b0;
    end else begin
      result.decode_class     = rid_pkg::CLASS_VALID;
      result.mnemonic_index   = code[6:0];
      result.control_transfer = rid_pkg::is_branch(code);
    end
  end

endmodule

/* hw/rtl/rid_out_reg.sv */
// rid_out_reg: result register feeding the output channel
module rid_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  rid_pkg::result_t up_result,
  output logic             out_valid,
  input  logic             out_ready,
  output rid_pkg::result_t out_result
);

  logic load;
  logic out_valid_next;

  // take a new result when empty or when the held one is taken
  assign up_ready = !out_valid || out_ready;
  assign load     = up_valid && up_ready;
  assign out_valid_next = load || (out_valid && !out_ready);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= up_result;
    end
  end

endmodule

/* tb/sv/tb_risc_instruction_decoder.sv */
// testbench for the instruction decoder: random and directed words checked against a table predictor
`timescale 1ns / 100ps

module tb_risc_instruction_decoder;

  // primary opcodes and function codes that steer the second-level decode
  localparam logic [5:0] OP_SPECIAL  = 6'b000000;
  localparam logic [5:0] OP_REGIMM   = 6'b000001;
  localparam logic [5:0] OP_POP06    = 6'b000110;
  localparam logic [5:0] OP_POP10    = 6'b001000;
  localparam logic [5:0] OP_POP30    = 6'b011000;
  localparam logic [5:0] OP_SPECIAL3 = 6'b011111;
  localparam logic [5:0] OP_POP66    = 6'b110110;
  localparam logic [5:0] OP_PCREL    = 6'b111011;
  localparam logic [5:0] OP_POP76    = 6'b111110;
  localparam logic [5:0] FN_SRL      = 6'd2;
  localparam logic [5:0] FN_SRLV     = 6'd6;
  localparam logic [5:0] FN_SOP30    = 6'd24;
  localparam logic [5:0] FN_SOP31    = 6'd25;
  localparam logic [5:0] FN_SOP33    = 6'd27;
  localparam logic [5:0] FN_BSHFL    = 6'b100000;

  localparam int RANDOM_WORDS = 1250;
  localparam int STALL_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 10;

  // decode maps: a mnemonic, a class code (high nibble F) or a group to decode further
  localparam logic [7:0] opcode_map [64] = '{
    rid_pkg::GR_SPECIAL, rid_pkg::GR_REGIMM, rid_pkg::MN_J, rid_pkg::MN_JAL,
    rid_pkg::MN_BEQ, rid_pkg::MN_BNE, rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD,
    rid_pkg::GR_POP10, rid_pkg::MN_ADDIU, rid_pkg::MN_SLTI, rid_pkg::MN_SLTIU,
    rid_pkg::MN_ANDI, rid_pkg::MN_ORI, rid_pkg::MN_XORI, rid_pkg::MN_AUI,
    rid_pkg::MN_COP0, rid_pkg::MN_COP1, rid_pkg::MN_COP2, rid_pkg::CL_REMOVED,
    rid_pkg::CL_REMOVED, rid_pkg::CL_REMOVED, rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD,
    rid_pkg::GR_POP30, rid_pkg::CL_RESB, rid_pkg::CL_RESB, rid_pkg::CL_RESB,
    rid_pkg::CL_RSTAR, rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD, rid_pkg::GR_SPECIAL3,
    rid_pkg::MN_LB, rid_pkg::MN_LH, rid_pkg::CL_REMOVED, rid_pkg::MN_LW,
    rid_pkg::MN_LBU, rid_pkg::MN_LHU, rid_pkg::CL_REMOVED, rid_pkg::CL_RESB,
    rid_pkg::MN_SB, rid_pkg::MN_SH, rid_pkg::CL_REMOVED, rid_pkg::MN_SW,
    rid_pkg::CL_RESB, rid_pkg::CL_RESB, rid_pkg::CL_REMOVED, rid_pkg::CL_REMOVED,
    rid_pkg::CL_REMOVED, rid_pkg::CL_NOMOD, rid_pkg::MN_BC, rid_pkg::CL_REMOVED,
    rid_pkg::CL_RESB, rid_pkg::CL_NOMOD, rid_pkg::GR_POP66, rid_pkg::CL_RESB,
    rid_pkg::CL_REMOVED, rid_pkg::CL_NOMOD, rid_pkg::MN_BALC, rid_pkg::GR_PCREL,
    rid_pkg::CL_RESB, rid_pkg::CL_NOMOD, rid_pkg::GR_POP76, rid_pkg::CL_RESB
  };

  localparam logic [7:0] special_map [64] = '{
    rid_pkg::MN_SLL, rid_pkg::CL_REMOVED, rid_pkg::GR_SRL, rid_pkg::MN_SRA,
    rid_pkg::MN_SLLV, rid_pkg::MN_LSA, rid_pkg::GR_SRLV, rid_pkg::MN_SRAV,
    rid_pkg::CL_REMOVED, rid_pkg::MN_JALR, rid_pkg::CL_REMOVED, rid_pkg::CL_REMOVED,
    rid_pkg::MN_SYSCALL, rid_pkg::MN_BREAK, rid_pkg::MN_SDBBP, rid_pkg::MN_SYNC,
    rid_pkg::MN_CLZ, rid_pkg::MN_CLO, rid_pkg::CL_REMOVED, rid_pkg::CL_REMOVED,
    rid_pkg::CL_RESB, rid_pkg::CL_RESB, rid_pkg::CL_RESB, rid_pkg::CL_RESB,
    rid_pkg::GR_SOP, rid_pkg::GR_SOP, rid_pkg::GR_SOP, rid_pkg::GR_SOP,
    rid_pkg::CL_RESB, rid_pkg::CL_RESB, rid_pkg::CL_RESB, rid_pkg::CL_RESB,
    rid_pkg::MN_ADD, rid_pkg::MN_ADDU, rid_pkg::MN_SUB, rid_pkg::MN_SUBU,
    rid_pkg::MN_AND, rid_pkg::MN_OR, rid_pkg::MN_XOR, rid_pkg::MN_NOR,
    rid_pkg::CL_RSTAR, rid_pkg::CL_RSTAR, rid_pkg::MN_SLT, rid_pkg::MN_SLTU,
    rid_pkg::CL_RESB, rid_pkg::CL_RESB, rid_pkg::CL_RESB, rid_pkg::CL_RESB,
    rid_pkg::MN_TGE, rid_pkg::MN_TGEU, rid_pkg::MN_TLT, rid_pkg::MN_TLTU,
    rid_pkg::MN_TEQ, rid_pkg::MN_SELEQZ, rid_pkg::MN_TNE, rid_pkg::MN_SELNEZ,
    rid_pkg::CL_RESB, rid_pkg::CL_RSTAR, rid_pkg::CL_RESB, rid_pkg::CL_RESB,
    rid_pkg::CL_RESB, rid_pkg::CL_RSTAR, rid_pkg::CL_RESB, rid_pkg::CL_RESB
  };

  localparam logic [7:0] regimm_map [32] = '{
    rid_pkg::MN_BLTZ, rid_pkg::MN_BGEZ, rid_pkg::CL_REMOVED, rid_pkg::CL_REMOVED,
    rid_pkg::CL_RSTAR, rid_pkg::CL_RSTAR, rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD,
    rid_pkg::CL_REMOVED, rid_pkg::CL_REMOVED, rid_pkg::CL_REMOVED, rid_pkg::CL_REMOVED,
    rid_pkg::CL_REMOVED, rid_pkg::CL_RSTAR, rid_pkg::CL_REMOVED, rid_pkg::CL_RSTAR,
    rid_pkg::CL_DEPR, rid_pkg::CL_DEPR, rid_pkg::CL_REMOVED, rid_pkg::CL_REMOVED,
    rid_pkg::CL_RSTAR, rid_pkg::CL_RSTAR, rid_pkg::CL_RSTAR, rid_pkg::MN_SIGRIE,
    rid_pkg::CL_RSTAR, rid_pkg::CL_RSTAR, rid_pkg::CL_RSTAR, rid_pkg::CL_RSTAR,
    rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD, rid_pkg::MN_SYNCI
  };

  localparam logic [7:0] special3_map [64] = '{
    rid_pkg::MN_EXT, rid_pkg::CL_RESB, rid_pkg::CL_RESB, rid_pkg::CL_RESB,
    rid_pkg::MN_INS, rid_pkg::CL_RESB, rid_pkg::CL_RESB, rid_pkg::CL_RESB,
    rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD, rid_pkg::CL_RSTAR,
    rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD, rid_pkg::CL_RSTAR, rid_pkg::CL_RSTAR,
    rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD,
    rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD,
    rid_pkg::CL_NOMOD, rid_pkg::CL_REMOVED, rid_pkg::CL_REMOVED, rid_pkg::CL_NOMOD,
    rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD,
    rid_pkg::GR_BSHFL, rid_pkg::CL_REMOVED, rid_pkg::CL_REMOVED, rid_pkg::CL_NOMOD,
    rid_pkg::CL_RESB, rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD, rid_pkg::CL_RESB,
    rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD, rid_pkg::CL_RSTAR, rid_pkg::CL_RSTAR,
    rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD,
    rid_pkg::CL_NOMOD, rid_pkg::CL_NOMOD, rid_pkg::CL_RSTAR, rid_pkg::CL_RSTAR,
    rid_pkg::CL_NOMOD, rid_pkg::MN_PREF, rid_pkg::MN_LL, rid_pkg::CL_RESB,
    rid_pkg::CL_NOMOD, rid_pkg::CL_RSTAR, rid_pkg::CL_RSTAR, rid_pkg::CL_NOMOD,
    rid_pkg::CL_NOMOD, rid_pkg::CL_RSTAR, rid_pkg::CL_RSTAR, rid_pkg::CL_RSTAR
  };

  // multiply/divide forms: {funct low bits, shamt bit 0 (high half or remainder select)}
  localparam logic [7:0] sop_map [8] = '{
    rid_pkg::MN_MUL, rid_pkg::MN_MUH, rid_pkg::MN_MULU, rid_pkg::MN_MUHU,
    rid_pkg::MN_DIV, rid_pkg::MN_MOD, rid_pkg::MN_DIVU, rid_pkg::MN_MODU
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] instruction_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  decode_class;
  logic [6:0]  mnemonic_index;
  logic        control_transfer;

  logic [31:0]      instr_queue [$];
  rid_pkg::result_t decode_due [$];
  int               fail_count = 0;
  int               cyc = 0;
  int               quiet_cycles = 0;

  risc_instruction_decoder DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .instruction_word (instruction_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .decode_class     (decode_class),
    .mnemonic_index   (mnemonic_index),
    .control_transfer (control_transfer)
  );

  // expected class, mnemonic and branch flag of one instruction word
  function automatic rid_pkg::result_t predict_decode(input logic [31:0] w);
    logic [5:0] op;
    logic [5:0] fn;
    logic [4:0] rs;
    logic [4:0] rt;
    logic [4:0] sa;
    logic [7:0] code;
    rid_pkg::result_t r;
    op   = w[31:26];
    rs   = w[25:21];
    rt   = w[20:16];
    sa   = w[10:6];
    fn   = w[5:0];
    code = opcode_map[op];
    case (code)
      rid_pkg::GR_SPECIAL: begin
        code = special_map[fn];
        if (code == rid_pkg::GR_SRL) begin
          if (w[21]) code = rid_pkg::MN_ROTR;
          else code = rid_pkg::MN_SRL;
        end else if (code == rid_pkg::GR_SRLV) begin
          if (w[6]) code = rid_pkg::MN_ROTRV;
          else code = rid_pkg::MN_SRLV;
        end else if (code == rid_pkg::GR_SOP) begin
          if (sa == 5'd2 || sa == 5'd3) code = sop_map[{fn[1:0], sa[0]}];
          else code = rid_pkg::CL_NOMOD;
        end
      end
      rid_pkg::GR_REGIMM: code = regimm_map[rt];
      rid_pkg::GR_POP10, rid_pkg::GR_POP30: begin
        // equal/not-equal pair when 0 < rs < rt, overflow pair when rs >= rt
        if (rs >= rt) begin
          code = (code == rid_pkg::GR_POP10) ? rid_pkg::MN_BOVC : rid_pkg::MN_BNVC;
        end else if (rs != 5'd0) begin
          code = (code == rid_pkg::GR_POP10) ? rid_pkg::MN_BEQC : rid_pkg::MN_BNEC;
        end else begin
          code = rid_pkg::CL_NOMOD;
        end
      end
      rid_pkg::GR_SPECIAL3: begin
        code = special3_map[fn];
        if (code == rid_pkg::GR_BSHFL) begin
          if (sa == 5'd0) code = rid_pkg::MN_BITSWAP;
          else if (sa == 5'd2) code = rid_pkg::MN_WSBH;
          else if (sa >= 5'd8 && sa <= 5'd11) code = rid_pkg::MN_ALIGN;
          else if (sa == 5'd16) code = rid_pkg::MN_SEB;
          else if (sa == 5'd24) code = rid_pkg::MN_SEH;
          else code = rid_pkg::CL_RSTAR;
        end
      end
      rid_pkg::GR_POP66: begin
        if (rs == 5'd0) code = rid_pkg::MN_JIC;
        else code = rid_pkg::CL_NOMOD;
      end
      rid_pkg::GR_POP76: begin
        if (rs == 5'd0) code = rid_pkg::MN_JIALC;
        else code = rid_pkg::CL_NOMOD;
      end
      rid_pkg::GR_PCREL: begin
        if (rt < 5'd8) code = rid_pkg::MN_ADDIUPC;
        else if (rt < 5'd16) code = rid_pkg::MN_LWPC;
        else if (rt < 5'd28) code = rid_pkg::CL_NOMOD;
        else if (rt == 5'd30) code = rid_pkg::MN_AUIPC;
        else if (rt == 5'd31) code = rid_pkg::MN_ALUIPC;
        else code = rid_pkg::CL_BAD;
      end
      default: ;
    endcase
    r = '0;
    if (code[7:4] == rid_pkg::CLASS_NIBBLE) begin
      r.decode_class = code[2:0];
    end else begin
      r.decode_class   = rid_pkg::CLASS_VALID;
      r.mnemonic_index = code[6:0];
      case (code)
        rid_pkg::MN_J, rid_pkg::MN_JAL, rid_pkg::MN_JALR, rid_pkg::MN_JIALC,
        rid_pkg::MN_JIC, rid_pkg::MN_BALC, rid_pkg::MN_BC, rid_pkg::MN_BEQ,
        rid_pkg::MN_BEQC, rid_pkg::MN_BGEZ, rid_pkg::MN_BLTZ, rid_pkg::MN_BNE,
        rid_pkg::MN_BNEC, rid_pkg::MN_BNVC, rid_pkg::MN_BOVC: r.control_transfer = 1'b1;
        default: r.control_transfer = 1'b0;
      endcase
    end
    return r;
  endfunction

  // instruction word from its fields, rd random
  function automatic logic [31:0] pack_word(input logic [5:0] op, input logic [4:0] rs,
                                            input logic [4:0] rt, input logic [4:0] sa,
                                            input logic [5:0] fn);
    logic [4:0] rd;
    rd = 5'($urandom_range(0, 31));
    return {op, rs, rt, rd, sa, fn};
  endfunction

  // random word, weighted towards the groups with a second level of decode
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        w[31:26] = OP_SPECIAL;
        if ($urandom_range(0, 1)) w[10:6] = 5'($urandom_range(0, 3));
      end
      3: w[31:26] = OP_REGIMM;
      4: begin
        w[31:26] = OP_SPECIAL3;
        if ($urandom_range(0, 1)) w[5:0] = FN_BSHFL;
      end
      5: begin
        w[31:26] = $urandom_range(0, 1) ? OP_POP10 : OP_POP30;
        if ($urandom_range(0, 1)) begin
          w[25:21] = 5'($urandom_range(0, 3));
          w[20:16] = 5'($urandom_range(0, 3));
        end
      end
      6: begin
        w[31:26] = $urandom_range(0, 1) ? OP_POP66 : OP_POP76;
        if ($urandom_range(0, 1)) w[25:21] = '0;
      end
      7: w[31:26] = OP_PCREL;
      default: ;
    endcase
    return w;
  endfunction

  // random idle, none during a stretch in the middle of the run
  function automatic logic idle_now();
    return !(cyc >= 600 && cyc < 1000) && ($urandom_range(0, 99) < 14);
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // instruction driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (instr_queue.size() != 0 && !idle_now()) begin
        in_valid         <= 1'b1;
        instruction_word <= instr_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_now();
    end
  end

  // predict on each input beat, compare on each output beat
  always @(posedge clk) begin
    rid_pkg::result_t want;
    if (!rst) begin
      if (in_valid && in_ready) decode_due.push_back(predict_decode(instruction_word));
      if (out_valid && out_ready) begin
        if (decode_due.size() == 0) begin
          $error("result beat with nothing expected: class %0d mnemonic %0d",
                 decode_class, mnemonic_index);
          fail_count++;
        end else begin
          want = decode_due.pop_front();
          if (decode_class !== want.decode_class) begin
            $error("decode_class: expected %0d, got %0d", want.decode_class, decode_class);
            fail_count++;
          end
          if (mnemonic_index !== want.mnemonic_index) begin
            $error("mnemonic_index: expected %0d, got %0d", want.mnemonic_index,
                   mnemonic_index);
            fail_count++;
          end
          if (control_transfer !== want.control_transfer) begin
            $error("control_transfer: expected %0d, got %0d", want.control_transfer,
                   control_transfer);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    // field extremes
    instr_queue.push_back(32'h0000_0000);
    instr_queue.push_back(32'hFFFF_FFFF);
    // shift versus rotate, immediate and variable forms
    instr_queue.push_back(pack_word(OP_SPECIAL, 5'd0, 5'd7, 5'd3, FN_SRL));
    instr_queue.push_back(pack_word(OP_SPECIAL, 5'd1, 5'd7, 5'd3, FN_SRL));
    instr_queue.push_back(pack_word(OP_SPECIAL, 5'd4, 5'd7, 5'd0, FN_SRLV));
    instr_queue.push_back(pack_word(OP_SPECIAL, 5'd4, 5'd7, 5'd1, FN_SRLV));
    // multiply/divide groups: low and high forms, then an unsupported shamt
    instr_queue.push_back(pack_word(OP_SPECIAL, 5'd2, 5'd3, 5'd2, FN_SOP30));
    instr_queue.push_back(pack_word(OP_SPECIAL, 5'd2, 5'd3, 5'd3, FN_SOP33));
    instr_queue.push_back(pack_word(OP_SPECIAL, 5'd2, 5'd3, 5'd0, FN_SOP31));
    // compact branch pairs
    instr_queue.push_back(pack_word(OP_POP10, 5'd1, 5'd2, 5'd0, 6'd0));
    instr_queue.push_back(pack_word(OP_POP10, 5'd5, 5'd5, 5'd0, 6'd0));
    instr_queue.push_back(pack_word(OP_POP10, 5'd0, 5'd3, 5'd0, 6'd0));
    instr_queue.push_back(pack_word(OP_POP30, 5'd3, 5'd31, 5'd0, 6'd0));
    instr_queue.push_back(pack_word(OP_POP30, 5'd0, 5'd31, 5'd0, 6'd0));
    instr_queue.push_back(pack_word(OP_POP66, 5'd0, 5'd9, 5'd0, 6'd0));
    instr_queue.push_back(pack_word(OP_POP66, 5'd1, 5'd9, 5'd0, 6'd0));
    instr_queue.push_back(pack_word(OP_POP76, 5'd0, 5'd9, 5'd0, 6'd0));
    instr_queue.push_back(pack_word(OP_POP06, 5'd3, 5'd4, 5'd0, 6'd0));
    // pc-relative group across its rt ranges
    instr_queue.push_back(pack_word(OP_PCREL, 5'd2, 5'd7, 5'd0, 6'd0));
    instr_queue.push_back(pack_word(OP_PCREL, 5'd2, 5'd20, 5'd0, 6'd0));
    instr_queue.push_back(pack_word(OP_PCREL, 5'd2, 5'd29, 5'd0, 6'd0));
    instr_queue.push_back(pack_word(OP_PCREL, 5'd2, 5'd30, 5'd0, 6'd0));
    instr_queue.push_back(pack_word(OP_PCREL, 5'd2, 5'd31, 5'd0, 6'd0));
    // byte shuffle group and a deprecated regimm entry
    instr_queue.push_back(pack_word(OP_SPECIAL3, 5'd0, 5'd1, 5'd0, FN_BSHFL));
    instr_queue.push_back(pack_word(OP_SPECIAL3, 5'd0, 5'd1, 5'd11, FN_BSHFL));
    instr_queue.push_back(pack_word(OP_SPECIAL3, 5'd0, 5'd1, 5'd31, FN_BSHFL));
    instr_queue.push_back(pack_word(OP_REGIMM, 5'd6, 5'd16, 5'd0, 6'd0));
    repeat (RANDOM_WORDS) instr_queue.push_back(random_word());

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // drain, then a short tail for stray beats
    while (instr_queue.size() != 0 || in_valid || decode_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && decode_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
